// ----- rtl/bscc_pkg.sv -----
// types, constants, helper functions and microcode for the balance speed cascade controller
`default_nettype none

package bscc_pkg;

    localparam int OPND_W = 25;
    localparam int PROD_W = 2 * OPND_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int RND_W  = ACC_W - 16;
    localparam int CFG_W  = 24;
    localparam int IDX_W  = 3;

    localparam int NUM_STEPS = 21;
    localparam int STEP_W    = $clog2(NUM_STEPS);

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE = STEP_W'(0);
    localparam step_t STEP_LAST = STEP_W'(NUM_STEPS - 1);

    typedef enum logic [IDX_W-1:0] {
        REG_SPEED_SETPOINT,
        REG_UPRIGHT_ANGLE,
        REG_TILT_GAIN_P,
        REG_TILT_GAIN_D,
        REG_SPEED_GAIN_P,
        REG_SPEED_GAIN_I,
        REG_FUSION_WEIGHT,
        REG_GYRO_STEP
    } reg_index_t;

    localparam logic signed [15:0] SPEED_SETPOINT_RST = 16'sd5120;
    localparam logic signed [16:0] UPRIGHT_ANGLE_RST  = 17'sd11008;
    localparam logic [23:0]        TILT_GAIN_P_RST    = 24'd524288;
    localparam logic [23:0]        TILT_GAIN_D_RST    = 24'd8192;
    localparam logic [23:0]        SPEED_GAIN_P_RST   = 24'd49152;
    localparam logic [23:0]        SPEED_GAIN_I_RST   = 24'd246;
    localparam logic [15:0]        FUSION_WEIGHT_RST  = 16'd1311;
    localparam logic [15:0]        GYRO_STEP_RST      = 16'd262;

    // speed smoothing weights, 0.7 and 0.3 in Q0.16
    localparam logic signed [OPND_W-1:0] W_NEW = OPND_W'(45875);
    localparam logic signed [OPND_W-1:0] W_OLD = OPND_W'(19661);
    localparam logic [16:0]              WEIGHT_ONE = 17'h10000;

    localparam logic signed [ACC_W-1:0] HALF_Q16 = ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] HALF_Q8  = ACC_W'(128);

    localparam logic signed [RND_W-1:0] TILT_MAX  = RND_W'(46080);
    localparam logic signed [RND_W-1:0] TILT_MIN  = -RND_W'(46080);
    localparam logic signed [RND_W-1:0] SPEED_MAX = RND_W'(524287);
    localparam logic signed [RND_W-1:0] SPEED_MIN = -RND_W'(524288);
    localparam logic signed [RND_W-1:0] VEL_MAX   = RND_W'(6400);
    localparam logic signed [RND_W-1:0] VEL_MIN   = -RND_W'(1792);
    localparam logic signed [RND_W-1:0] DRIVE_MAX = RND_W'(32767);
    localparam logic signed [RND_W-1:0] DRIVE_MIN = -RND_W'(32768);

    localparam logic signed [21:0] INTEG_MAX = 22'sd256000;
    localparam logic signed [21:0] INTEG_MIN = -22'sd256000;
    localparam logic signed [20:0] ERR_GATE_MAX = 21'sd2048;
    localparam logic signed [20:0] ERR_GATE_MIN = -21'sd2048;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_GYRO_STEP,
        MUL_RC_NEW,
        MUL_RS_OLD,
        MUL_PRED,
        MUL_W_ACCEL,
        MUL_LC_NEW,
        MUL_LS_OLD,
        MUL_KPS_ERR,
        MUL_KIS_INT,
        MUL_KD_GYRO,
        MUL_KPT_DIFF
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_GATED
    } acc_op_t;

    typedef enum logic [3:0] {
        WB_NONE,
        WB_PRED,
        WB_RS,
        WB_TILT,
        WB_LS,
        WB_MEAN,
        WB_ERR,
        WB_INTEG,
        WB_VEL,
        WB_TARGET,
        WB_DIFF
    } wb_sel_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_WAIT_OUT
    } seq_t;

    typedef struct packed {
        mul_sel_t mul;
        acc_op_t  acc;
        wb_sel_t  wb;
        seq_t     seq;
    } uword_t;

    function automatic logic signed [RND_W-1:0] sat(
        input logic signed [RND_W-1:0] v,
        input logic signed [RND_W-1:0] lo,
        input logic signed [RND_W-1:0] hi
    );
        logic signed [RND_W-1:0] r;
        r = v;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    // control program, one word per step
    function automatic uword_t ucode(input step_t pc);
        uword_t uw;
        uw.mul = MUL_NONE;
        uw.acc = ACC_HOLD;
        uw.wb  = WB_NONE;
        uw.seq = SEQ_NEXT;
        case (pc)
            STEP_W'(0):
            begin
                uw.seq = SEQ_WAIT_IN;
            end
            STEP_W'(1):
            begin
                uw.mul = MUL_GYRO_STEP;
            end
            STEP_W'(2):
            begin
                uw.acc = ACC_LOAD;
                uw.mul = MUL_RC_NEW;
            end
            STEP_W'(3):
            begin
                uw.wb  = WB_PRED;
                uw.acc = ACC_LOAD;
                uw.mul = MUL_RS_OLD;
            end
            STEP_W'(4):
            begin
                uw.acc = ACC_ADD;
                uw.mul = MUL_PRED;
            end
            STEP_W'(5):
            begin
                uw.wb  = WB_RS;
                uw.acc = ACC_LOAD;
                uw.mul = MUL_W_ACCEL;
            end
            STEP_W'(6):
            begin
                uw.acc = ACC_ADD;
                uw.mul = MUL_LC_NEW;
            end
            STEP_W'(7):
            begin
                uw.wb  = WB_TILT;
                uw.acc = ACC_LOAD;
                uw.mul = MUL_LS_OLD;
            end
            STEP_W'(8):
            begin
                uw.acc = ACC_ADD;
            end
            STEP_W'(9):
            begin
                uw.wb = WB_LS;
            end
            STEP_W'(10):
            begin
                uw.wb = WB_MEAN;
            end
            STEP_W'(11):
            begin
                uw.wb = WB_ERR;
            end
            STEP_W'(12):
            begin
                uw.wb  = WB_INTEG;
                uw.mul = MUL_KPS_ERR;
            end
            STEP_W'(13):
            begin
                uw.acc = ACC_LOAD;
                uw.mul = MUL_KIS_INT;
            end
            STEP_W'(14):
            begin
                uw.acc = ACC_ADD_GATED;
            end
            STEP_W'(15):
            begin
                uw.wb  = WB_VEL;
                uw.mul = MUL_KD_GYRO;
            end
            STEP_W'(16):
            begin
                uw.wb  = WB_TARGET;
                uw.acc = ACC_LOAD;
            end
            STEP_W'(17):
            begin
                uw.wb = WB_DIFF;
            end
            STEP_W'(18):
            begin
                uw.mul = MUL_KPT_DIFF;
            end
            STEP_W'(19):
            begin
                uw.acc = ACC_ADD;
            end
            STEP_W'(20):
            begin
                uw.seq = SEQ_WAIT_OUT;
            end
            default:
            begin
                uw.seq = SEQ_NEXT;
            end
        endcase
        return uw;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/balance_speed_cascade_controller.sv -----
// balance speed cascade controller: microcoded sequencer around one shared multiplier
//
// One input transfer is one control tick: accelerometer tilt, gyro rate and both
// encoder counts. Each tick gives exactly one result transfer: balance drive, fused
// tilt, mean wheel speed, tilt target and the integral limit flag.
// in_ready is high only while the sequencer sits in its idle step. After a transfer
// the program runs 20 steps on one 25x25 signed multiplier with a product register
// and a 51-bit accumulator; eleven products go through it one after another.
// out_valid rises once the last step has loaded the output register; a new input is
// taken only after that, when the sequencer is back in its idle step.
// The result sits in an output register; if it has not been taken when the next
// result is ready, the last step holds until out_ready frees the register.
// Configuration writes take effect at once; the user is to make them while the block is idle (not enforced).
// Reset loads the register defaults, clears the filter, speed and integral state
// and leaves the block idle with no result pending.
`default_nettype none

module balance_speed_cascade_controller
    import bscc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    cfg_wen,
    input  wire logic [IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,

    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic signed [16:0]      accel_tilt,
    input  wire logic signed [15:0]      gyro_rate,
    input  wire logic signed [11:0]      right_count,
    input  wire logic signed [11:0]      left_count,

    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [15:0]           balance_drive,
    output logic signed [16:0]           tilt_estimate,
    output logic signed [19:0]           mean_speed,
    output logic signed [16:0]           tilt_target,
    output logic                         integral_clamped
);

    // configuration
    logic signed [15:0] setpoint_reg;
    logic signed [16:0] upright_reg;
    logic [23:0]        kpt_reg;
    logic [23:0]        kdt_reg;
    logic [23:0]        kps_reg;
    logic [23:0]        kis_reg;
    logic [15:0]        weight_reg;
    logic [15:0]        gstep_reg;

    // sequencer
    step_t  pc_reg;
    step_t  pc_next;
    uword_t uw;
    logic   out_load;

    // input item
    logic signed [16:0] accel_reg;
    logic signed [15:0] gyro_reg;
    logic signed [11:0] rc_reg;
    logic signed [11:0] lc_reg;

    // loop state
    logic signed [16:0] tilt_reg;
    logic signed [19:0] rs_reg;
    logic signed [19:0] ls_reg;
    logic signed [18:0] integ_reg;
    logic signed [16:0] tilt_next;
    logic signed [19:0] speed_next;
    logic signed [18:0] integ_next;
    logic               clamp_next;

    // datapath
    logic signed [OPND_W-1:0] mul_a;
    logic signed [OPND_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_q8;
    logic signed [ACC_W-1:0]  acc_q16;
    logic signed [RND_W-1:0]  rnd16;

    logic signed [OPND_W-1:0] pred_reg;
    logic signed [OPND_W-1:0] pred_next;
    logic signed [19:0]       mean_reg;
    logic signed [20:0]       speed_sum;
    logic signed [20:0]       err_reg;
    logic signed [20:0]       err_next;
    logic signed [21:0]       integ_sum;
    logic                     gate_reg;
    logic                     gate_next;
    logic                     clamp_reg;
    logic signed [13:0]       vel_reg;
    logic signed [17:0]       target_sum;
    logic signed [16:0]       target_reg;
    logic signed [16:0]       target_next;
    logic signed [17:0]       diff_reg;
    logic signed [15:0]       drive_next;

    // result register
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [15:0]       drive_out_reg;
    logic signed [16:0]       tilt_out_reg;
    logic signed [19:0]       mean_out_reg;
    logic signed [16:0]       target_out_reg;
    logic                     clamp_out_reg;

    assign uw = ucode(pc_reg);

    // sequencer next step and handshake
    always_comb
    begin
        in_ready = (uw.seq == SEQ_WAIT_IN);
        out_load = (uw.seq == SEQ_WAIT_OUT) && (!out_valid_reg || out_ready);
        case (uw.seq)
            SEQ_WAIT_IN:
            begin
                pc_next = in_valid ? step_t'(pc_reg + 1'b1) : pc_reg;
            end
            SEQ_WAIT_OUT:
            begin
                pc_next = out_load ? STEP_IDLE : pc_reg;
            end
            default:
            begin
                pc_next = step_t'(pc_reg + 1'b1);
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (uw.mul)
            MUL_GYRO_STEP:
            begin
                mul_a = OPND_W'(gstep_reg);
                mul_b = OPND_W'(gyro_reg);
            end
            MUL_RC_NEW:
            begin
                mul_a = W_NEW;
                mul_b = OPND_W'($signed({rc_reg, 8'h00}));
            end
            MUL_RS_OLD:
            begin
                mul_a = W_OLD;
                mul_b = OPND_W'(rs_reg);
            end
            MUL_PRED:
            begin
                mul_a = OPND_W'(WEIGHT_ONE - {1'b0, weight_reg});
                mul_b = pred_reg;
            end
            MUL_W_ACCEL:
            begin
                mul_a = OPND_W'(weight_reg);
                mul_b = OPND_W'(accel_reg);
            end
            MUL_LC_NEW:
            begin
                mul_a = W_NEW;
                mul_b = OPND_W'($signed({lc_reg, 8'h00}));
            end
            MUL_LS_OLD:
            begin
                mul_a = W_OLD;
                mul_b = OPND_W'(ls_reg);
            end
            MUL_KPS_ERR:
            begin
                mul_a = OPND_W'(kps_reg);
                mul_b = OPND_W'(err_reg);
            end
            MUL_KIS_INT:
            begin
                mul_a = OPND_W'(kis_reg);
                mul_b = OPND_W'(integ_reg);
            end
            MUL_KD_GYRO:
            begin
                mul_a = OPND_W'(kdt_reg);
                mul_b = OPND_W'($signed({gyro_reg, 8'h00}));
            end
            MUL_KPT_DIFF:
            begin
                mul_a = OPND_W'(kpt_reg);
                mul_b = OPND_W'(diff_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        case (uw.acc)
            ACC_LOAD:
            begin
                acc_next = ACC_W'(prod_reg);
            end
            ACC_ADD:
            begin
                acc_next = acc_reg + ACC_W'(prod_reg);
            end
            ACC_ADD_GATED:
            begin
                acc_next = gate_reg ? acc_reg + ACC_W'(prod_reg) : acc_reg;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // rounding, saturation and loop arithmetic
    always_comb
    begin
        acc_q8      = (acc_reg + HALF_Q8) >>> 8;
        acc_q16     = (acc_reg + HALF_Q16) >>> 16;
        rnd16       = acc_q16[RND_W-1:0];
        pred_next   = OPND_W'(tilt_reg) - acc_q8[OPND_W-1:0];
        tilt_next   = 17'(sat(rnd16, TILT_MIN, TILT_MAX));
        speed_next  = 20'(sat(rnd16, SPEED_MIN, SPEED_MAX));
        speed_sum   = 21'(ls_reg) + 21'(rs_reg);
        err_next    = 21'(setpoint_reg) - 21'(mean_reg);
        integ_sum   = 22'(integ_reg) + 22'(err_reg);
        gate_next   = (err_reg < ERR_GATE_MAX) && (err_reg > ERR_GATE_MIN);
        clamp_next  = 1'b0;
        integ_next  = integ_sum[18:0];
        if (integ_sum > INTEG_MAX)
        begin
            integ_next = INTEG_MAX[18:0];
            clamp_next = 1'b1;
        end
        else if (integ_sum < INTEG_MIN)
        begin
            integ_next = INTEG_MIN[18:0];
            clamp_next = 1'b1;
        end
        target_sum  = 18'(upright_reg) + 18'(vel_reg);
        target_next = 17'(sat(RND_W'(target_sum), TILT_MIN, TILT_MAX));
        drive_next  = 16'(sat(rnd16, DRIVE_MIN, DRIVE_MAX));
    end

    // control, configuration and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= STEP_IDLE;
            out_valid_reg <= 1'b0;
            setpoint_reg  <= SPEED_SETPOINT_RST;
            upright_reg   <= UPRIGHT_ANGLE_RST;
            kpt_reg       <= TILT_GAIN_P_RST;
            kdt_reg       <= TILT_GAIN_D_RST;
            kps_reg       <= SPEED_GAIN_P_RST;
            kis_reg       <= SPEED_GAIN_I_RST;
            weight_reg    <= FUSION_WEIGHT_RST;
            gstep_reg     <= GYRO_STEP_RST;
            tilt_reg      <= '0;
            rs_reg        <= '0;
            ls_reg        <= '0;
            integ_reg     <= '0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                case (reg_index_t'(cfg_index))
                    REG_SPEED_SETPOINT: setpoint_reg <= cfg_data[15:0];
                    REG_UPRIGHT_ANGLE:  upright_reg  <= cfg_data[16:0];
                    REG_TILT_GAIN_P:    kpt_reg      <= cfg_data[23:0];
                    REG_TILT_GAIN_D:    kdt_reg      <= cfg_data[23:0];
                    REG_SPEED_GAIN_P:   kps_reg      <= cfg_data[23:0];
                    REG_SPEED_GAIN_I:   kis_reg      <= cfg_data[23:0];
                    REG_FUSION_WEIGHT:  weight_reg   <= cfg_data[15:0];
                    REG_GYRO_STEP:      gstep_reg    <= cfg_data[15:0];
                    default:            ;
                endcase
            end
            case (uw.wb)
                WB_TILT:  tilt_reg  <= tilt_next;
                WB_RS:    rs_reg    <= speed_next;
                WB_LS:    ls_reg    <= speed_next;
                WB_INTEG: integ_reg <= integ_next;
                default:  ;
            endcase
        end
    end

    // datapath and result payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            accel_reg <= accel_tilt;
            gyro_reg  <= gyro_rate;
            rc_reg    <= right_count;
            lc_reg    <= left_count;
        end
        if (uw.mul != MUL_NONE)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
        case (uw.wb)
            WB_PRED:   pred_reg   <= pred_next;
            WB_MEAN:   mean_reg   <= speed_sum[20:1];
            WB_ERR:    err_reg    <= err_next;
            WB_INTEG:
            begin
                clamp_reg <= clamp_next;
                gate_reg  <= gate_next;
            end
            WB_VEL:    vel_reg    <= 14'(sat(rnd16, VEL_MIN, VEL_MAX));
            WB_TARGET: target_reg <= target_next;
            WB_DIFF:   diff_reg   <= 18'(target_reg) - 18'(tilt_reg);
            default:   ;
        endcase
        if (out_load)
        begin
            drive_out_reg  <= drive_next;
            tilt_out_reg   <= tilt_reg;
            mean_out_reg   <= mean_reg;
            target_out_reg <= target_reg;
            clamp_out_reg  <= clamp_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign balance_drive    = drive_out_reg;
    assign tilt_estimate    = tilt_out_reg;
    assign mean_speed       = mean_out_reg;
    assign tilt_target      = target_out_reg;
    assign integral_clamped = clamp_out_reg;

`ifndef NO_ASSERTIONS
    a_result_from_last_step: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pc_reg == STEP_LAST)
    ) else $error("result appeared outside the final step");

    a_idle_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (pc_reg == STEP_IDLE && !in_valid) |=> (pc_reg == STEP_IDLE)
    ) else $error("sequencer left idle without an input transfer");

    a_integ_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        (22'(integ_reg) <= INTEG_MAX) && (22'(integ_reg) >= INTEG_MIN)
    ) else $error("speed integral outside its limit");

    a_tilt_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        (RND_W'(tilt_reg) <= TILT_MAX) && (RND_W'(tilt_reg) >= TILT_MIN)
    ) else $error("tilt state outside its limit");

    a_stall_holds_step: assert property (
        @(posedge clk) disable iff (!rst_n)
        (pc_reg == STEP_LAST && out_valid_reg && !out_ready) |=> (pc_reg == STEP_LAST)
    ) else $error("final step left while the result register was full");
`endif

endmodule

`default_nettype wire
